// ----- rtl/cawf_pkg.sv -----
package cawf_pkg;

    localparam int unsigned ACTION_W = 5;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BITSEL_W = 3;

    localparam logic [ACTION_W-1:0] ACT_ADD        = 5'd0;
    localparam logic [ACTION_W-1:0] ACT_ADC        = 5'd1;
    localparam logic [ACTION_W-1:0] ACT_SUB        = 5'd2;
    localparam logic [ACTION_W-1:0] ACT_SBC        = 5'd3;
    localparam logic [ACTION_W-1:0] ACT_AND        = 5'd4;
    localparam logic [ACTION_W-1:0] ACT_XOR        = 5'd5;
    localparam logic [ACTION_W-1:0] ACT_OR         = 5'd6;
    localparam logic [ACTION_W-1:0] ACT_CP         = 5'd7;
    localparam logic [ACTION_W-1:0] ACT_INC        = 5'd8;
    localparam logic [ACTION_W-1:0] ACT_DEC        = 5'd9;
    localparam logic [ACTION_W-1:0] ACT_RLC        = 5'd10;
    localparam logic [ACTION_W-1:0] ACT_RRC        = 5'd11;
    localparam logic [ACTION_W-1:0] ACT_RL         = 5'd12;
    localparam logic [ACTION_W-1:0] ACT_RR         = 5'd13;
    localparam logic [ACTION_W-1:0] ACT_SLA        = 5'd14;
    localparam logic [ACTION_W-1:0] ACT_SRA        = 5'd15;
    localparam logic [ACTION_W-1:0] ACT_SRL        = 5'd16;
    localparam logic [ACTION_W-1:0] ACT_SWAP       = 5'd17;
    localparam logic [ACTION_W-1:0] ACT_BIT        = 5'd18;
    localparam logic [ACTION_W-1:0] ACT_DAA        = 5'd19;
    localparam logic [ACTION_W-1:0] ACT_CPL        = 5'd20;
    localparam logic [ACTION_W-1:0] ACT_CCF        = 5'd21;
    localparam logic [ACTION_W-1:0] ACT_SCF        = 5'd22;
    localparam logic [ACTION_W-1:0] ACT_RLCA       = 5'd23;
    localparam logic [ACTION_W-1:0] ACT_RRCA       = 5'd24;
    localparam logic [ACTION_W-1:0] ACT_RLA        = 5'd25;
    localparam logic [ACTION_W-1:0] ACT_RRA        = 5'd26;
    localparam logic [ACTION_W-1:0] ACT_ADD16      = 5'd27;
    localparam logic [ACTION_W-1:0] ACT_SP_OFFSET  = 5'd28;
    localparam logic [ACTION_W-1:0] ACT_LOAD_FLAGS = 5'd29;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [WORD_W-1:0]   operand_a;
        logic [WORD_W-1:0]   operand_b;
        logic [BITSEL_W-1:0] bit_index;
    } request_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              write_back;
        logic              zero_flag;
        logic              subtract_flag;
        logic              half_carry_flag;
        logic              carry_flag;
    } result_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

endpackage

// ----- rtl/cawf_alu.sv -----
module cawf_alu
    import cawf_pkg::*;
(
    input  request_t req,
    input  flags_t   flags,
    output result_t  rsp
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              cin;
    logic              t_add;
    logic              t_sub;
    logic [BYTE_W:0]   sum9;
    logic [4:0]        sum_lo;
    logic [BYTE_W:0]   diff9;
    logic [4:0]        diff_lo;
    logic [BYTE_W-1:0] rot_r;
    logic              rot_c;
    logic [BYTE_W-1:0] daa_r;
    logic              daa_c;
    logic [WORD_W:0]   sum17;
    logic [12:0]       sum13;
    logic [WORD_W-1:0] sp_sum;
    logic [BYTE_W:0]   sp9;
    logic [4:0]        sp_lo;
    logic [BYTE_W-1:0] r8;
    logic [WORD_W-1:0] r16;
    logic              wide;
    logic              wb;
    flags_t            f;

    assign a     = req.operand_a[BYTE_W-1:0];
    assign b     = req.operand_b[BYTE_W-1:0];
    assign cin   = flags.c;
    assign t_add = (req.action == ACT_ADC) ? cin : 1'b0;
    assign t_sub = (req.action == ACT_SBC) ? cin : 1'b0;

    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, t_add};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t_add};
    assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, t_sub};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t_sub};

    assign sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    assign sum13  = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
    assign sp_sum = req.operand_a + {{8{b[7]}}, b};
    assign sp9    = {1'b0, a} + {1'b0, b};
    assign sp_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]};

    always_comb
    begin
        rot_r = a;
        rot_c = 1'b0;
        case (req.action) inside
            ACT_RLC, ACT_RLCA:
            begin
                rot_c = a[7];
                rot_r = {a[6:0], a[7]};
            end
            ACT_RRC, ACT_RRCA:
            begin
                rot_c = a[0];
                rot_r = {a[0], a[7:1]};
            end
            ACT_RL, ACT_RLA:
            begin
                rot_c = a[7];
                rot_r = {a[6:0], cin};
            end
            ACT_RR, ACT_RRA:
            begin
                rot_c = a[0];
                rot_r = {cin, a[7:1]};
            end
            ACT_SLA:
            begin
                rot_c = a[7];
                rot_r = {a[6:0], 1'b0};
            end
            ACT_SRA:
            begin
                rot_c = a[0];
                rot_r = {a[7], a[7:1]};
            end
            default:
            begin
                rot_c = a[0];
                rot_r = {1'b0, a[7:1]};
            end
        endcase
    end

    always_comb
    begin
        daa_r = a;
        daa_c = cin;
        if (!flags.n)
        begin
            if (cin || (a > 8'h99))
            begin
                daa_r = daa_r + 8'h60;
                daa_c = 1'b1;
            end
            if (flags.h || (a[3:0] > 4'd9))
            begin
                daa_r = daa_r + 8'h06;
            end
        end
        else
        begin
            if (cin)
            begin
                daa_r = daa_r - 8'h60;
            end
            if (flags.h)
            begin
                daa_r = daa_r - 8'h06;
            end
        end
    end

    always_comb
    begin
        r8   = '0;
        r16  = '0;
        wide = 1'b0;
        wb   = 1'b1;
        f    = flags;
        unique case (req.action) inside
            ACT_ADD, ACT_ADC:
            begin
                r8 = sum9[7:0];
                f  = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
            end
            ACT_SUB, ACT_SBC, ACT_CP:
            begin
                r8 = diff9[7:0];
                wb = (req.action != ACT_CP);
                f  = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
            end
            ACT_AND:
            begin
                r8 = a & b;
                f  = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            ACT_XOR:
            begin
                r8 = a ^ b;
                f  = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            ACT_OR:
            begin
                r8 = a | b;
                f  = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            ACT_INC:
            begin
                r8 = a + 8'd1;
                f  = '{z: (a == 8'hff), n: 1'b0, h: (a[3:0] == 4'hf), c: cin};
            end
            ACT_DEC:
            begin
                r8 = a - 8'd1;
                f  = '{z: (a == 8'h01), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
            end
            ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SRL:
            begin
                r8 = rot_r;
                f  = '{z: (rot_r == 8'd0), n: 1'b0, h: 1'b0, c: rot_c};
            end
            ACT_RLCA, ACT_RRCA, ACT_RLA, ACT_RRA:
            begin
                r8 = rot_r;
                f  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_c};
            end
            ACT_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                f  = '{z: (a == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            ACT_BIT:
            begin
                r8 = a;
                wb = 1'b0;
                f  = '{z: !a[req.bit_index], n: 1'b0, h: 1'b1, c: cin};
            end
            ACT_DAA:
            begin
                r8 = daa_r;
                f  = '{z: (daa_r == 8'd0), n: flags.n, h: 1'b0, c: daa_c};
            end
            ACT_CPL:
            begin
                r8 = ~a;
                f  = '{z: flags.z, n: 1'b1, h: 1'b1, c: cin};
            end
            ACT_CCF:
            begin
                wb = 1'b0;
                f  = '{z: flags.z, n: 1'b0, h: 1'b0, c: !cin};
            end
            ACT_SCF:
            begin
                wb = 1'b0;
                f  = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            ACT_ADD16:
            begin
                wide = 1'b1;
                r16  = sum17[WORD_W-1:0];
                f    = '{z: flags.z, n: 1'b0, h: sum13[12], c: sum17[WORD_W]};
            end
            ACT_SP_OFFSET:
            begin
                wide = 1'b1;
                r16  = sp_sum;
                f    = '{z: 1'b0, n: 1'b0, h: sp_lo[4], c: sp9[8]};
            end
            ACT_LOAD_FLAGS:
            begin
                r8 = {b[7:4], 4'd0};
                wb = 1'b0;
                f  = '{z: b[7], n: b[6], h: b[5], c: b[4]};
            end
            default:
            begin
                wb = 1'b0;
            end
        endcase
    end

    assign rsp.result          = wide ? r16 : {8'd0, r8};
    assign rsp.write_back      = wb;
    assign rsp.zero_flag       = f.z;
    assign rsp.subtract_flag   = f.n;
    assign rsp.half_carry_flag = f.h;
    assign rsp.carry_flag      = f.c;

endmodule

// ----- rtl/cpu_alu_with_flags.sv -----
// An accepted request is registered at the input, and its result is then registered at the output.
// One request per cycle while the result side is not stalled; the flag register feeds the next request directly.
// A stalled result holds in the output register while one more request waits at the input.
// Reset clears both valid bits and sets all four flags to zero.
module cpu_alu_with_flags
    import cawf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     request_valid,
    output logic     request_ready,
    input  request_t request,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result_item
);

    logic     in_valid_reg;
    logic     in_valid_next;
    request_t in_data_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_data_reg;
    flags_t   flags_reg;
    flags_t   flags_next;
    result_t  alu_rsp;
    logic     advance;
    logic     take;

    cawf_alu u_alu (
        .req   (in_data_reg),
        .flags (flags_reg),
        .rsp   (alu_rsp)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || result_ready);
    assign request_ready = !in_valid_reg || advance;
    assign take          = request_valid && request_ready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result_ready);
    assign flags_next     = advance ? flags_t'{z: alu_rsp.zero_flag, n: alu_rsp.subtract_flag,
                                               h: alu_rsp.half_carry_flag, c: alu_rsp.carry_flag}
                                    : flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= request;
        end
        if (advance)
        begin
            out_data_reg <= alu_rsp;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (flags_reg == $past(flags_reg)))
        else $error("Flags changed without a request moving to the output.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flags_reg == {out_data_reg.zero_flag, out_data_reg.subtract_flag,
                                         out_data_reg.half_carry_flag, out_data_reg.carry_flag}))
        else $error("Flag register disagrees with the flags of the last result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !request_ready |-> (in_valid_reg && out_valid_reg && !result_ready))
        else $error("Request side stalled without a full pipeline.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("Stalled result was lost or changed.");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import cawf_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_REQUESTS = 1750;
    localparam int MAX_WAIT = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam logic [ACTION_W-1:0] ACT_RSVD_A = 5'd30;
    localparam logic [ACTION_W-1:0] ACT_RSVD_B = 5'd31;

    class flag_alu_scoreboard;
        flags_t  flags;
        result_t pending_results[$];
        int      errors;
        int      requests;
        int      results;
        bit      action_seen[32];

        function new();
            flags = '0;
            errors = 0;
            requests = 0;
            results = 0;
        endfunction

        function result_t compute_alu(request_t req);
            logic [7:0]  a;
            logic [7:0]  b;
            logic [7:0]  r;
            logic [15:0] r16;
            logic [8:0]  sum;
            logic [4:0]  nib;
            logic [16:0] wide;
            logic [12:0] mid;
            logic        ci;
            logic        c;
            logic        wb;
            flags_t      f;
            result_t     res;
            a = req.operand_a[7:0];
            b = req.operand_b[7:0];
            f = flags;
            ci = flags.c;
            r = 8'h00;
            r16 = 16'h0000;
            wb = 1'b1;
            case (req.action)
                ACT_ADD, ACT_ADC: begin
                    c = (req.action == ACT_ADC) ? ci : 1'b0;
                    sum = {1'b0, a} + {1'b0, b} + {8'h00, c};
                    nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
                    r = sum[7:0];
                    f = {r == 8'h00, 1'b0, nib[4], sum[8]};
                end
                ACT_SUB, ACT_SBC, ACT_CP: begin
                    c = (req.action == ACT_SBC) ? ci : 1'b0;
                    sum = {1'b0, a} - {1'b0, b} - {8'h00, c};
                    nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, c};
                    r = sum[7:0];
                    f = {r == 8'h00, 1'b1, nib[4], sum[8]};
                    if (req.action == ACT_CP)
                        wb = 1'b0;
                end
                ACT_AND: begin
                    r = a & b;
                    f = {r == 8'h00, 1'b0, 1'b1, 1'b0};
                end
                ACT_XOR: begin
                    r = a ^ b;
                    f = {r == 8'h00, 3'b000};
                end
                ACT_OR: begin
                    r = a | b;
                    f = {r == 8'h00, 3'b000};
                end
                ACT_INC: begin
                    r = a + 8'h01;
                    f = {r == 8'h00, 1'b0, a[3:0] == 4'hf, ci};
                end
                ACT_DEC: begin
                    r = a - 8'h01;
                    f = {r == 8'h00, 1'b1, a[3:0] == 4'h0, ci};
                end
                ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SRL,
                ACT_RLCA, ACT_RRCA, ACT_RLA, ACT_RRA: begin
                    case (req.action)
                        ACT_RLC, ACT_RLCA: begin c = a[7]; r = {a[6:0], a[7]}; end
                        ACT_RRC, ACT_RRCA: begin c = a[0]; r = {a[0], a[7:1]}; end
                        ACT_RL, ACT_RLA:   begin c = a[7]; r = {a[6:0], ci}; end
                        ACT_RR, ACT_RRA:   begin c = a[0]; r = {ci, a[7:1]}; end
                        ACT_SLA:           begin c = a[7]; r = {a[6:0], 1'b0}; end
                        ACT_SRA:           begin c = a[0]; r = {a[7], a[7:1]}; end
                        default:           begin c = a[0]; r = {1'b0, a[7:1]}; end
                    endcase
                    f = {(req.action < ACT_RLCA) && (r == 8'h00), 1'b0, 1'b0, c};
                end
                ACT_SWAP: begin
                    r = {a[3:0], a[7:4]};
                    f = {r == 8'h00, 3'b000};
                end
                ACT_BIT: begin
                    r = a;
                    wb = 1'b0;
                    f = {a[req.bit_index] == 1'b0, 1'b0, 1'b1, ci};
                end
                ACT_DAA: begin
                    c = ci;
                    r = a;
                    if (!flags.n) begin
                        if (c || a > 8'h99) begin
                            r = r + 8'h60;
                            c = 1'b1;
                        end
                        if (flags.h || a[3:0] > 4'd9)
                            r = r + 8'h06;
                    end
                    else begin
                        if (c)
                            r = r - 8'h60;
                        if (flags.h)
                            r = r - 8'h06;
                    end
                    f = {r == 8'h00, flags.n, 1'b0, c};
                end
                ACT_CPL: begin
                    r = ~a;
                    f = {flags.z, 1'b1, 1'b1, flags.c};
                end
                ACT_CCF: begin
                    wb = 1'b0;
                    f = {flags.z, 1'b0, 1'b0, ~ci};
                end
                ACT_SCF: begin
                    wb = 1'b0;
                    f = {flags.z, 1'b0, 1'b0, 1'b1};
                end
                ACT_ADD16: begin
                    wide = {1'b0, req.operand_a} + {1'b0, req.operand_b};
                    mid = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
                    r16 = wide[15:0];
                    f = {flags.z, 1'b0, mid[12], wide[16]};
                end
                ACT_SP_OFFSET: begin
                    r16 = req.operand_a + {{8{b[7]}}, b};
                    sum = {1'b0, a} + {1'b0, b};
                    nib = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                    f = {1'b0, 1'b0, nib[4], sum[8]};
                end
                ACT_LOAD_FLAGS: begin
                    f = req.operand_b[7:4];
                    r = {req.operand_b[7:4], 4'h0};
                    wb = 1'b0;
                end
                default: begin
                    wb = 1'b0;
                end
            endcase
            flags = f;
            res.result = (req.action == ACT_ADD16 || req.action == ACT_SP_OFFSET) ?
                         r16 : {8'h00, r};
            res.write_back = wb;
            res.zero_flag = f.z;
            res.subtract_flag = f.n;
            res.half_carry_flag = f.h;
            res.carry_flag = f.c;
            return res;
        endfunction

        function void note_request(request_t req);
            requests++;
            action_seen[req.action] = 1'b1;
            pending_results.push_back(compute_alu(req));
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: result %h arrived with no request waiting", $time, got);
            end
            else begin
                want = pending_results.pop_front();
                compare("result", want.result, got.result);
                compare("write_back", 16'(want.write_back), 16'(got.write_back));
                compare("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
                compare("subtract_flag", 16'(want.subtract_flag), 16'(got.subtract_flag));
                compare("half_carry_flag", 16'(want.half_carry_flag),
                        16'(got.half_carry_flag));
                compare("carry_flag", 16'(want.carry_flag), 16'(got.carry_flag));
            end
        endfunction

        function int actions_covered();
            int n;
            n = 0;
            foreach (action_seen[i])
                if (action_seen[i])
                    n++;
            return n;
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     request_valid;
    logic     request_ready;
    request_t request;
    logic     result_valid;
    logic     result_ready;
    result_t  result_item;

    flag_alu_scoreboard sb = new();
    bit quiet;
    int cycles;

    cpu_alu_with_flags uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_item   (result_item)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (request_valid && request_ready)
                sb.note_request(request);
            if (result_valid && result_ready)
                sb.check_result(result_item);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, sb.pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic issue(logic [ACTION_W-1:0] action, logic [WORD_W-1:0] a,
                         logic [WORD_W-1:0] b, logic [BITSEL_W-1:0] idx);
        int gap;
        gap = quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
        if (gap > 0) begin
            request_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request.action = action;
        request.operand_a = a;
        request.operand_b = b;
        request.bit_index = idx;
        request_valid = 1'b1;
        do @(posedge clk); while (!request_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        request_valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h00ff;
            3: return 16'h0080;
            4: return {8'h00, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_bcd();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom_range(0, 9));
        lo = 4'($urandom_range(0, 9));
        return {8'($urandom), hi, lo};
    endfunction

    initial
    begin
        rst_n = 1'b0;
        request_valid = 1'b0;
        request = '0;
        quiet = 1'b0;
        cycles = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
    end

    initial
    begin
        int stall;
        result_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            stall = quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
            if (stall > 0) begin
                result_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready = 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int issued;
        logic [ACTION_W-1:0] arith;
        wait (rst_n);
        @(negedge clk);
        @(negedge clk);

        issue(ACT_ADD, 16'h00ff, 16'h0001, 3'd0);
        issue(ACT_ADC, 16'h0000, 16'h0000, 3'd0);
        issue(ACT_SUB, 16'h0000, 16'h0001, 3'd0);
        issue(ACT_SBC, 16'h0010, 16'h0000, 3'd0);
        issue(ACT_AND, 16'h00f0, 16'h000f, 3'd0);
        issue(ACT_XOR, 16'hffaa, 16'h00aa, 3'd0);
        issue(ACT_OR, 16'h0000, 16'hff00, 3'd0);
        issue(ACT_CP, 16'h0042, 16'h0042, 3'd0);
        issue(ACT_INC, 16'h00ff, 16'h0000, 3'd0);
        issue(ACT_DEC, 16'h0010, 16'h0000, 3'd0);
        issue(ACT_RLC, 16'h0080, 16'h0000, 3'd0);
        issue(ACT_RRC, 16'h0001, 16'h0000, 3'd0);
        issue(ACT_RL, 16'h0080, 16'h0000, 3'd0);
        issue(ACT_RR, 16'h0001, 16'h0000, 3'd0);
        issue(ACT_SLA, 16'h0080, 16'h0000, 3'd0);
        issue(ACT_SRA, 16'h0081, 16'h0000, 3'd0);
        issue(ACT_SRL, 16'h0001, 16'h0000, 3'd0);
        issue(ACT_SWAP, 16'h00f0, 16'h0000, 3'd0);
        issue(ACT_BIT, 16'h007f, 16'h0000, 3'd7);
        issue(ACT_ADD, 16'h0015, 16'h0027, 3'd0);
        issue(ACT_DAA, 16'h003c, 16'h0000, 3'd0);
        issue(ACT_SUB, 16'h0042, 16'h0015, 3'd0);
        issue(ACT_DAA, 16'h002d, 16'h0000, 3'd0);
        issue(ACT_CPL, 16'h0055, 16'h0000, 3'd0);
        issue(ACT_CCF, 16'h0000, 16'h0000, 3'd0);
        issue(ACT_SCF, 16'h0000, 16'h0000, 3'd0);
        issue(ACT_RLCA, 16'h0080, 16'h0000, 3'd0);
        issue(ACT_RRCA, 16'h0000, 16'h0000, 3'd0);
        issue(ACT_RLA, 16'h0080, 16'h0000, 3'd0);
        issue(ACT_RRA, 16'h0001, 16'h0000, 3'd0);
        issue(ACT_ADD16, 16'hffff, 16'h0001, 3'd0);
        issue(ACT_SP_OFFSET, 16'h000f, 16'h00ff, 3'd0);
        issue(ACT_LOAD_FLAGS, 16'h0000, 16'h00f0, 3'd0);
        issue(ACT_RSVD_A, 16'hffff, 16'hffff, 3'd7);
        issue(ACT_RSVD_B, 16'hffff, 16'hffff, 3'd7);
        drain();

        // Most use a random action; others: optional flag load, BCD arithmetic, decimal adjust.
        issued = 0;
        while (issued < RANDOM_REQUESTS) begin
            if (issued % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (issued % 400 == 399)
                drain();
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    issue(ACT_LOAD_FLAGS, pick_word(), 16'($urandom), 3'($urandom));
                    issued++;
                end
                case ($urandom_range(0, 3))
                    0: arith = ACT_ADD;
                    1: arith = ACT_ADC;
                    2: arith = ACT_SUB;
                    default: arith = ACT_SBC;
                endcase
                issue(arith, pick_bcd(), pick_bcd(), 3'($urandom));
                issue(ACT_DAA, pick_word(), pick_word(), 3'($urandom));
                issued += 2;
            end
            else begin
                issue(5'($urandom), pick_word(), pick_word(), 3'($urandom));
                issued++;
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Checked %0d results from %0d requests across %0d action codes.",
                 sb.results, sb.requests, sb.actions_covered());
        $display("Mismatches found: %0d.", sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
